### rtl/nla_pkg.sv
// Shared types and constants for the nearest landmark association unit.
// Used by nla_sqdist, nearest_landmark_association_unit and the testbench files; depends on nothing.
package nla_pkg;

	localparam int MAX_LANDMARKS = 64;
	localparam int IDX_W = $clog2(MAX_LANDMARKS);
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
	localparam int ID_W = 16;
	localparam int COORD_BITS = 24;
	localparam int PROD_W = 2 * COORD_BITS;
	localparam int DIST_W = PROD_W + 1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MULX,
		S_MULY,
		S_ADD,
		S_CMP,
		S_DONE
	} state_t;

	// One stored landmark, identifier in the low bits.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] x;
		logic [ID_W-1:0]              id;
	} entry_t;

	// Control of the shared squared-distance unit.
	typedef struct packed {
		logic mul_en;
		logic sel_y;
		logic acc_load;
		logic acc_add;
	} sq_ctl_t;

endpackage

### rtl/nla_sqdist.sv
// Shared squared-distance unit: one abs-difference and one squarer, used for x then y.
// Depends on nla_pkg.
module nla_sqdist (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  nla_pkg::sq_ctl_t                       ctl,
	input  logic signed [nla_pkg::COORD_BITS-1:0]  qry_x,
	input  logic signed [nla_pkg::COORD_BITS-1:0]  qry_y,
	input  logic signed [nla_pkg::COORD_BITS-1:0]  lm_x,
	input  logic signed [nla_pkg::COORD_BITS-1:0]  lm_y,
	output logic [nla_pkg::DIST_W-1:0]             sq_dist
);

	logic signed [nla_pkg::COORD_BITS:0] diff;
	logic [nla_pkg::COORD_BITS-1:0]      mag;
	logic [nla_pkg::PROD_W-1:0]          prod_q;
	logic [nla_pkg::DIST_W-1:0]          sum_q;

	// The difference of two coordinates always has a magnitude that fits COORD_BITS.
	always_comb begin
		if (ctl.sel_y) begin
			diff = {qry_y[nla_pkg::COORD_BITS-1], qry_y} - {lm_y[nla_pkg::COORD_BITS-1], lm_y};
		end else begin
			diff = {qry_x[nla_pkg::COORD_BITS-1], qry_x} - {lm_x[nla_pkg::COORD_BITS-1], lm_x};
		end
		if (diff[nla_pkg::COORD_BITS]) begin
			mag = nla_pkg::COORD_BITS'(-diff);
		end else begin
			mag = nla_pkg::COORD_BITS'(diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			sum_q  <= '0;
		end else begin
			if (ctl.mul_en) begin
				prod_q <= nla_pkg::PROD_W'(mag) * nla_pkg::PROD_W'(mag);
			end
			if (ctl.acc_load) begin
				sum_q <= nla_pkg::DIST_W'(prod_q);
			end else if (ctl.acc_add) begin
				sum_q <= sum_q + nla_pkg::DIST_W'(prod_q);
			end
		end
	end

	assign sq_dist = sum_q;

endmodule

### rtl/nearest_landmark_association_unit.sv
// Nearest landmark association: a landmark store with a sequential nearest search.
// Depends on nla_pkg and nla_sqdist.
// Clear and load requests are taken in S_IDLE and keep it there. A query runs READ,
// MULX, MULY, ADD, CMP per loaded landmark, then DONE (empty store: DONE at once),
// on the single shared squarer and memory read port; the block is busy meanwhile.
// Reset (arst_n low) empties the store and clears the overflow flag at once.
module nearest_landmark_association_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // lm_ident[15:0], obs_x[39:16], obs_y[63:40]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // nearest_id[15:0]
	output logic [1:0]  m_tuser    // found[0], overflow[1]
);

	nla_pkg::state_t                       state_q, state_nx;
	nla_pkg::cmd_t                         cmd;
	nla_pkg::sq_ctl_t                      sq_ctl;
	nla_pkg::entry_t                       mem [nla_pkg::MAX_LANDMARKS];
	nla_pkg::entry_t                       wr_entry;
	nla_pkg::entry_t                       rd_q;
	logic [nla_pkg::CNT_W-1:0]             count_q;
	logic [nla_pkg::CNT_W-1:0]             idx_next;
	logic [nla_pkg::IDX_W-1:0]             idx_q;
	logic                                  dropped_q;
	logic signed [nla_pkg::COORD_BITS-1:0] qry_x_q, qry_y_q;
	logic [nla_pkg::DIST_W-1:0]            sq_dist;
	logic [nla_pkg::DIST_W-1:0]            best_dist_q;
	logic [nla_pkg::ID_W-1:0]              best_id_q;
	logic                                  accept, full, last;
	logic                                  wr_en, rd_en, cmp_en, out_load;
	logic                                  best_upd;
	logic                                  out_valid_q, found_q, ovf_q;
	logic [nla_pkg::ID_W-1:0]              out_id_q;

	assign cmd      = nla_pkg::cmd_t'(s_tuser);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == nla_pkg::CNT_W'(nla_pkg::MAX_LANDMARKS));
	assign idx_next = {1'b0, idx_q} + nla_pkg::CNT_W'(1);
	assign last     = (idx_next == count_q);
	assign s_tready = (state_q == nla_pkg::S_IDLE);

	assign wr_entry.id = s_tdata[15:0];
	assign wr_entry.x  = s_tdata[39:16];
	assign wr_entry.y  = s_tdata[63:40];

	// Next state of the search sequencer.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			nla_pkg::S_IDLE: begin
				if (accept && cmd == nla_pkg::CMD_QUERY) begin
					state_nx = (count_q == '0) ? nla_pkg::S_DONE : nla_pkg::S_READ;
				end
			end
			nla_pkg::S_READ: state_nx = nla_pkg::S_MULX;
			nla_pkg::S_MULX: state_nx = nla_pkg::S_MULY;
			nla_pkg::S_MULY: state_nx = nla_pkg::S_ADD;
			nla_pkg::S_ADD:  state_nx = nla_pkg::S_CMP;
			nla_pkg::S_CMP:  state_nx = last ? nla_pkg::S_DONE : nla_pkg::S_READ;
			nla_pkg::S_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_nx = nla_pkg::S_IDLE;
				end
			end
			default: state_nx = nla_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: memory strobes, squarer control and result capture.
	always_comb begin
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		cmp_en   = 1'b0;
		out_load = 1'b0;
		sq_ctl   = '0;
		case (state_q)
			nla_pkg::S_IDLE: wr_en = accept && cmd == nla_pkg::CMD_LOAD && !full;
			nla_pkg::S_READ: rd_en = 1'b1;
			nla_pkg::S_MULX: sq_ctl.mul_en = 1'b1;
			nla_pkg::S_MULY: begin
				sq_ctl.mul_en   = 1'b1;
				sq_ctl.sel_y    = 1'b1;
				sq_ctl.acc_load = 1'b1;
			end
			nla_pkg::S_ADD:  sq_ctl.acc_add = 1'b1;
			nla_pkg::S_CMP:  cmp_en = 1'b1;
			nla_pkg::S_DONE: out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// The first landmark always wins; later ones only when strictly closer, so
	// ties keep the earliest load.
	assign best_upd = cmp_en && (idx_q == '0 || sq_dist < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nla_pkg::S_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				case (cmd)
					nla_pkg::CMD_CLEAR: begin
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
					nla_pkg::CMD_LOAD: begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + nla_pkg::CNT_W'(1);
						end
					end
					nla_pkg::CMD_QUERY: idx_q <= '0;
					default: ;
				endcase
			end
			if (cmp_en && !last) begin
				idx_q <= idx_next[nla_pkg::IDX_W-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: query point, running best and the output request.
	always_ff @(posedge clk) begin
		if (accept && cmd == nla_pkg::CMD_QUERY) begin
			qry_x_q <= s_tdata[39:16];
			qry_y_q <= s_tdata[63:40];
		end
		if (best_upd) begin
			best_dist_q <= sq_dist;
			best_id_q   <= rd_q.id;
		end
		if (out_load) begin
			found_q  <= (count_q != '0);
			out_id_q <= (count_q != '0) ? best_id_q : '0;
			ovf_q    <= dropped_q;
		end
	end

	// Landmark memory: one write port for loads, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[nla_pkg::IDX_W-1:0]] <= wr_entry;
		end
		if (rd_en) begin
			rd_q <= mem[idx_q];
		end
	end

	nla_sqdist u_sqdist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sq_ctl),
		.qry_x   (qry_x_q),
		.qry_y   (qry_y_q),
		.lm_x    (rd_q.x),
		.lm_y    (rd_q.y),
		.sq_dist (sq_dist)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_id_q;
	assign m_tuser  = {ovf_q, found_q};

	// The store never holds more landmarks than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nla_pkg::CNT_W'(nla_pkg::MAX_LANDMARKS))
		else $error("landmark count exceeds store depth");

	// The scan index stays below the number of loaded landmarks.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nla_pkg::S_READ || state_q == nla_pkg::S_CMP) |-> ({1'b0, idx_q} < count_q))
		else $error("scan index beyond loaded landmarks");

	// A query on an empty store goes straight to the result.
	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == nla_pkg::CMD_QUERY && count_q == '0) |=> (state_q == nla_pkg::S_DONE))
		else $error("empty query did not skip the scan");

	// The overflow flag only rises on a load into a full store.
	a_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> $past(accept && cmd == nla_pkg::CMD_LOAD && full))
		else $error("overflow flag set without a dropped load");

	// A result that found nothing carries a zero identifier.
	a_not_found_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("nonzero identifier on a not-found result");

endmodule

### tb/sv/landmark_match_checker.sv
`timescale 1ns / 1ps
// Checker for the nearest landmark association unit: watches both streams,
// keeps its own landmark store and predicts each query answer. Depends on nla_pkg.
module landmark_match_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // lm_ident[15:0], obs_x[39:16], obs_y[63:40]
	input  logic [1:0]  s_tuser,   // command[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // nearest_id[15:0]
	input  logic [1:0]  m_tuser,   // found[0], overflow[1]
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic                     found;
		logic [nla_pkg::ID_W-1:0] nearest_id;
		logic                     overflow;
	} match_t;

	nla_pkg::entry_t landmarks [nla_pkg::MAX_LANDMARKS];
	int unsigned     loaded;
	logic            lost_load;
	int unsigned     slips;
	match_t          pending_matches [$];
	match_t          want;

	task automatic report_slip(input string what);
		slips++;
		$display("landmark check failed at %0t ns: %s", $time, what);
	endtask

	// Scan in load order; a strict less-than keeps the earliest landmark on ties.
	function automatic match_t nearest_landmark(logic signed [nla_pkg::COORD_BITS-1:0] qx,
			logic signed [nla_pkg::COORD_BITS-1:0] qy);
		match_t                       ans;
		logic [nla_pkg::COORD_BITS:0] dx;
		logic [nla_pkg::COORD_BITS:0] dy;
		logic [63:0]                  sq_sum;
		logic [63:0]                  best;
		ans.found = 1'b0;
		ans.nearest_id = '0;
		ans.overflow = lost_load;
		best = '0;
		for (int i = 0; i < loaded; i++) begin
			dx = {qx[nla_pkg::COORD_BITS-1], qx}
				- {landmarks[i].x[nla_pkg::COORD_BITS-1], landmarks[i].x};
			dy = {qy[nla_pkg::COORD_BITS-1], qy}
				- {landmarks[i].y[nla_pkg::COORD_BITS-1], landmarks[i].y};
			if (dx[nla_pkg::COORD_BITS]) dx = -dx;
			if (dy[nla_pkg::COORD_BITS]) dy = -dy;
			sq_sum = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
			if (!ans.found || sq_sum < best) begin
				ans.found = 1'b1;
				ans.nearest_id = landmarks[i].id;
				best = sq_sum;
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded = 0;
			lost_load = 1'b0;
			slips = 0;
			pending_matches.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_matches.size() == 0) begin
					report_slip($sformatf("result id %h flags %b with no query waiting",
						m_tdata, m_tuser));
				end else begin
					want = pending_matches.pop_front();
					if (m_tuser[0] !== want.found)
						report_slip($sformatf("found %b, predicted %b", m_tuser[0], want.found));
					if (m_tdata !== want.nearest_id)
						report_slip($sformatf("nearest_id %h, predicted %h",
							m_tdata, want.nearest_id));
					if (m_tuser[1] !== want.overflow)
						report_slip($sformatf("overflow %b, predicted %b",
							m_tuser[1], want.overflow));
				end
			end
			if (s_tvalid && s_tready) begin
				case (nla_pkg::cmd_t'(s_tuser))
					nla_pkg::CMD_CLEAR: begin
						loaded = 0;
						lost_load = 1'b0;
					end
					nla_pkg::CMD_LOAD: begin
						if (loaded >= nla_pkg::MAX_LANDMARKS) begin
							lost_load = 1'b1;
						end else begin
							landmarks[loaded] = '{y: s_tdata[63:40], x: s_tdata[39:16],
								id: s_tdata[15:0]};
							loaded++;
						end
					end
					nla_pkg::CMD_QUERY: begin
						pending_matches = {pending_matches,
							nearest_landmark(s_tdata[39:16], s_tdata[63:40])};
					end
					default: begin
					end
				endcase
			end
			mismatches <= slips;
			outstanding <= pending_matches.size();
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for nearest_landmark_association_unit: clock, reset and
// request stimulus. Depends on nla_pkg, the unit itself and landmark_match_checker.
module testbench;

	// The random part stops after this many counted requests (ignored commands
	// do not count), or later if too few queries have been made by then.
	localparam int unsigned RANDOM_ITEMS = 650;
	localparam int unsigned MIN_QUERIES = 60;
	// The drain after the last answer is comfortably longer than a query on a
	// full store takes.
	localparam int unsigned DRAIN_CYCLES = 8 * nla_pkg::MAX_LANDMARKS;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam logic [nla_pkg::COORD_BITS-1:0] COORD_MAX =
		{1'b0, {(nla_pkg::COORD_BITS-1){1'b1}}};
	localparam logic [nla_pkg::COORD_BITS-1:0] COORD_MIN =
		{1'b1, {(nla_pkg::COORD_BITS-1){1'b0}}};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = nla_pkg::CMD_CLEAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned ticks = 0;

	// Requests counted toward the stimulus length, and queries among them.
	int unsigned made = 0;
	int unsigned asked = 0;

	// Positions loaded since the last clear, used to aim queries at exact
	// landmark positions and to place landmarks on top of each other for ties.
	logic [nla_pkg::COORD_BITS-1:0] spots_x [$];
	logic [nla_pkg::COORD_BITS-1:0] spots_y [$];

	// A long stretch of the random part runs with neither side idling.
	wire steady = (made >= 250) && (made < 400);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	nearest_landmark_association_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	landmark_match_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// The result side stalls at random, about 14 percent of the time, outside the
	// steady stretch. Inputs only ever change on the falling edge.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 14);
	end

	// Guard against a hang: a stuck handshake or an answer that never comes.
	always @(posedge clk) begin
		ticks <= ticks + 1;
		if (ticks == CYCLE_LIMIT) begin
			$display("nearest_landmark_association_unit: mismatch");
			$finish;
		end
	end

	// Presents one request and returns at the rising edge that accepts it.
	// Idle cycles before it carry random data with tvalid low; each signal is
	// assigned at most once per falling edge.
	task automatic send_request(input nla_pkg::cmd_t op, input logic [nla_pkg::ID_W-1:0] id,
			input logic [nla_pkg::COORD_BITS-1:0] x, input logic [nla_pkg::COORD_BITS-1:0] y);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom};
			s_tuser <= 2'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {y, x, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op != nla_pkg::CMD_NONE) made++;
		if (op == nla_pkg::CMD_QUERY) asked++;
		if (op == nla_pkg::CMD_CLEAR) begin
			spots_x.delete();
			spots_y.delete();
		end
		if (op == nla_pkg::CMD_LOAD) begin
			spots_x = {spots_x, x};
			spots_y = {spots_y, y};
		end
	endtask

	// Mostly points near a cluster center, with some full-range values and
	// some at the ends of the coordinate range.
	function automatic logic [nla_pkg::COORD_BITS-1:0] pick_coord(
			logic [nla_pkg::COORD_BITS-1:0] center, int unsigned spread);
		case ($urandom_range(0, 9))
			0: begin
				return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			end
			1: begin
				return nla_pkg::COORD_BITS'($urandom);
			end
			default: begin
				return center + nla_pkg::COORD_BITS'($urandom_range(0, 2 * spread))
					- nla_pkg::COORD_BITS'(spread);
			end
		endcase
	endfunction

	initial begin
		int unsigned pick;
		int unsigned loads;
		int unsigned spread;
		int unsigned k;
		logic [nla_pkg::COORD_BITS-1:0] cx;
		logic [nla_pkg::COORD_BITS-1:0] cy;
		logic [nla_pkg::ID_W-1:0] id;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A query right after reset sees an empty store.
		send_request(nla_pkg::CMD_QUERY, 16'h0000, '0, '0);
		// The unused command code must leave everything alone.
		send_request(nla_pkg::CMD_NONE, 16'hFFFF, COORD_MAX, COORD_MIN);
		// Landmarks at both corners of the range, the second one loaded twice
		// under different identifiers so that the earlier one must win the tie.
		send_request(nla_pkg::CMD_LOAD, 16'hFFFF, COORD_MAX, COORD_MAX);
		send_request(nla_pkg::CMD_LOAD, 16'h0000, COORD_MIN, COORD_MIN);
		send_request(nla_pkg::CMD_LOAD, 16'h1234, COORD_MIN, COORD_MIN);
		send_request(nla_pkg::CMD_QUERY, 16'hFFFF, COORD_MIN, COORD_MIN);
		send_request(nla_pkg::CMD_QUERY, 16'h0000, COORD_MAX, COORD_MAX);
		// A point equally far from both corners: first one wins.
		send_request(nla_pkg::CMD_QUERY, 16'h5555, COORD_MAX, COORD_MIN);
		send_request(nla_pkg::CMD_QUERY, 16'hAAAA, COORD_MIN, COORD_MAX);
		// Two landmarks 256 either side of the origin tie on a query there.
		send_request(nla_pkg::CMD_LOAD, 16'h00A5, nla_pkg::COORD_BITS'(256), '0);
		send_request(nla_pkg::CMD_LOAD, 16'h5A00, -nla_pkg::COORD_BITS'(256), '0);
		send_request(nla_pkg::CMD_QUERY, 16'h0000, '0, '0);
		send_request(nla_pkg::CMD_QUERY, 16'h0000, -nla_pkg::COORD_BITS'(1), '0);
		send_request(nla_pkg::CMD_NONE, 16'h0000, '0, '0);
		// A clear empties the store again.
		send_request(nla_pkg::CMD_CLEAR, 16'hFFFF, COORD_MAX, COORD_MAX);
		send_request(nla_pkg::CMD_QUERY, 16'hFFFF, nla_pkg::COORD_BITS'(1),
			-nla_pkg::COORD_BITS'(1));
		send_request(nla_pkg::CMD_LOAD, 16'h8001, -nla_pkg::COORD_BITS'(1),
			nla_pkg::COORD_BITS'(1));
		send_request(nla_pkg::CMD_QUERY, 16'h0000, COORD_MIN, COORD_MAX);
		send_request(nla_pkg::CMD_CLEAR, 16'h0000, '0, '0);

		// Random part: runs of a clear (most of the time), loads and queries with random content.
		// Some runs fill the store and spill over, which sets the overflow flag.
		while (made < RANDOM_ITEMS || asked < MIN_QUERIES) begin
			if ($urandom_range(0, 99) < 85)
				send_request(nla_pkg::CMD_CLEAR, nla_pkg::ID_W'($urandom),
					nla_pkg::COORD_BITS'($urandom), nla_pkg::COORD_BITS'($urandom));
			pick = $urandom_range(0, 99);
			if (pick < 60)
				loads = $urandom_range(1, 6);
			else if (pick < 85)
				loads = $urandom_range(7, 40);
			else
				loads = $urandom_range(nla_pkg::MAX_LANDMARKS - 4, nla_pkg::MAX_LANDMARKS + 6);
			case ($urandom_range(0, 2))
				0: spread = 16;
				1: spread = 1024;
				default: spread = 1 << 20;
			endcase
			cx = nla_pkg::COORD_BITS'($urandom);
			cy = nla_pkg::COORD_BITS'($urandom);
			repeat (loads) begin
				id = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
					: nla_pkg::ID_W'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					// Noise: any command, the unused one included.
					send_request(nla_pkg::cmd_t'($urandom_range(0, 3)), id,
						nla_pkg::COORD_BITS'($urandom), nla_pkg::COORD_BITS'($urandom));
				end else if (pick < 14 && spots_x.size() != 0) begin
					// Same position as an earlier landmark, to make ties.
					k = $urandom_range(0, spots_x.size() - 1);
					send_request(nla_pkg::CMD_LOAD, id, spots_x[k], spots_y[k]);
				end else begin
					send_request(nla_pkg::CMD_LOAD, id, pick_coord(cx, spread),
						pick_coord(cy, spread));
				end
			end
			repeat ($urandom_range(1, 5)) begin
				if (spots_x.size() != 0 && $urandom_range(0, 4) == 0) begin
					k = $urandom_range(0, spots_x.size() - 1);
					send_request(nla_pkg::CMD_QUERY, nla_pkg::ID_W'($urandom),
						spots_x[k], spots_y[k]);
				end else begin
					send_request(nla_pkg::CMD_QUERY, nla_pkg::ID_W'($urandom),
						pick_coord(cx, spread), pick_coord(cy, spread));
				end
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;

		// Wait for every predicted answer, then a while longer so that an
		// extra result would still be caught.
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("nearest_landmark_association_unit: match");
		end else begin
			$display("nearest_landmark_association_unit: mismatch");
		end
		$finish;
	end

endmodule
